@@ rtl/core/b64d_pkg.sv @@
`timescale 1ns / 1ps

package b64d_pkg;

    // Kind of one result item, carried on m_tuser.
    typedef enum logic [1:0] {
        KIND_BYTE       = 2'd0,
        KIND_BAD_CHAR   = 2'd1,
        KIND_BAD_LENGTH = 2'd2
    } result_kind_t;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam int         QDEPTH     = 4;
    localparam int         QPTR_W     = $clog2(QDEPTH);
    localparam int         QCNT_W     = QPTR_W + 1;

    // One finished quad as handed from the front end to the back end.
    typedef struct packed {
        logic [23:0]  group;
        result_kind_t kind;
        logic [1:0]   count;   // number of results, 1 to 3
    } quad_cmd_t;

    // Queue status seen by the front end and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] sextet;
    } sextet_t;

    // Maps one character of the alphabet to its sextet; '=' counts as zero.
    function automatic sextet_t char_to_sextet(input logic [7:0] c);
        sextet_t r;
        r.valid  = 1'b1;
        r.sextet = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.sextet = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.sextet = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.sextet = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.sextet = 6'd62;
        end else if (c == 8'h2F) begin
            r.sextet = 6'd63;
        end else if (c == PAD_CHAR) begin
            r.sextet = 6'd0;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/b64d_front.sv @@
`timescale 1ns / 1ps

module b64d_front import b64d_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] in_char
    input  logic          s_tlast,   // end_of_text
    input  queue_status_t q_status,
    output logic          push,
    output quad_cmd_t     push_cmd
);

    logic [17:0] accum_reg, accum_next;
    logic [1:0]  pos_reg, pos_next;
    logic        bad_reg, bad_next;
    logic        third_pad_reg, third_pad_next;

    sextet_t     dec;
    logic        accept;
    logic        is_pad;
    logic        bad_now;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign dec      = char_to_sextet(s_tdata);
    assign is_pad   = (s_tdata == PAD_CHAR);
    assign bad_now  = bad_reg || !dec.valid;

    always_comb begin
        accum_next     = accum_reg;
        pos_next       = pos_reg;
        bad_next       = bad_reg;
        third_pad_next = third_pad_reg;
        push           = 1'b0;
        push_cmd.group = {accum_reg, dec.sextet};
        push_cmd.kind  = KIND_BYTE;
        push_cmd.count = 2'd3;
        if (accept) begin
            if (pos_reg != 2'd3) begin
                accum_next = {accum_reg[11:0], dec.sextet};
                pos_next   = pos_reg + 2'd1;
                bad_next   = bad_now;
                if (pos_reg == 2'd2) begin
                    third_pad_next = is_pad;
                end
                if (s_tlast) begin
                    // A short final quad is a length error, whatever it holds.
                    push           = 1'b1;
                    push_cmd.kind  = KIND_BAD_LENGTH;
                    push_cmd.count = 2'd1;
                end
            end else begin
                push = 1'b1;
                if (bad_now) begin
                    push_cmd.kind  = KIND_BAD_CHAR;
                    push_cmd.count = 2'd1;
                end else if (s_tlast) begin
                    push_cmd.count = 2'd3 - {1'b0, third_pad_reg} - {1'b0, is_pad};
                end
            end
            if (push) begin
                accum_next     = '0;
                pos_next       = 2'd0;
                bad_next       = 1'b0;
                third_pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg     <= '0;
            pos_reg       <= 2'd0;
            bad_reg       <= 1'b0;
            third_pad_reg <= 1'b0;
        end else begin
            accum_reg     <= accum_next;
            pos_reg       <= pos_next;
            bad_reg       <= bad_next;
            third_pad_reg <= third_pad_next;
        end
    end

endmodule

@@ rtl/core/b64d_queue.sv @@
`timescale 1ns / 1ps

module b64d_queue import b64d_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  quad_cmd_t     push_cmd,
    input  logic          pop,
    output quad_cmd_t     head,
    output queue_status_t status
);

    quad_cmd_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/core/b64d_back.sv @@
`timescale 1ns / 1ps

module b64d_back import b64d_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  quad_cmd_t     head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_byte
    output logic [1:0]    m_tuser,   // [1:0] result_kind
    output logic          m_tlast    // run_last
);

    logic [1:0]   idx_reg, idx_next;
    logic         valid_reg, valid_next;
    logic [7:0]   data_reg, data_next;
    result_kind_t kind_reg, kind_next;
    logic         last_reg, last_next;

    logic         load;
    logic         is_last;
    logic [7:0]   sel_byte;

    // The output register takes a new result whenever it is empty or being drained.
    assign load    = !q_status.empty && (!valid_reg || m_tready);
    assign is_last = (idx_reg == head.count - 2'd1);
    assign pop     = load && is_last;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head.group[23:16];
            2'd1:    sel_byte = head.group[15:8];
            default: sel_byte = head.group[7:0];
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = (head.kind == KIND_BYTE) ? sel_byte : 8'h00;
            kind_next  = head.kind;
            last_next  = is_last;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/core/base64_decoder.sv @@
`timescale 1ns / 1ps
// Streaming base64 decoder.
// The slave channel takes one character per request: s_tdata holds the
// character and s_tlast marks the final character of the text. The master
// channel gives one result per request: m_tdata holds a decoded byte,
// m_tuser the result kind (byte, invalid character, bad length) and m_tlast
// marks the last result caused by one input character.
// A complete quad gives three bytes, fewer on the final quad for each '='
// in the third or fourth place, or one invalid character result. A text
// that ends in mid-quad gives one length error result.
// Throughput: one character per cycle while s_tready is high; the output
// register also moves one result per cycle while m_tready is high, so
// three bytes per four characters fit with room. The character that ends
// a quad writes the quad queue; the output register then loads the
// quad's first result from the queue head.
// A four-entry quad queue sits between the front end and the output side;
// s_tready drops only when the queue is full.
// Reset clears the quad state, the queue and the output register.
module base64_decoder import b64d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] result_kind
    output logic       m_tlast    // run_last
);

    queue_status_t q_status;
    logic          push;
    quad_cmd_t     push_cmd;
    logic          pop;
    quad_cmd_t     head;

    b64d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    b64d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    b64d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/core/b64d_checker.sv @@
`timescale 1ns / 1ps

module b64d_checker import b64d_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result holds until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Error results stand alone and carry a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_BYTE |-> m_tlast && m_tdata == 8'h00)
        else $error("error result not single or not zero");

    // The bytes of one quad follow each other without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == KIND_BYTE)
        else $error("gap inside a quad's bytes");

    // Only decoded bytes can be followed by more results of the same character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == KIND_BYTE)
        else $error("error result without last mark");

    // Reset empties the output.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind base64_decoder b64d_checker u_chk (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import b64d_pkg::*;

    // One decoded result as the output side should deliver it.
    typedef struct {
        bit [7:0]     data;
        result_kind_t kind;
        bit           last;
    } decoded_t;

    // Tracks the quad state of the decoder and holds the results still owed.
    class DecodeScoreboard;
        decoded_t owed_results[$];
        bit [17:0] sextet_acc;
        bit [1:0]  quad_pos;
        bit        bad_seen;
        bit        pad_third;
        int        errors;
        int        chars_in;
        int        bytes_out;
        int        bad_char_quads;
        int        length_errors;

        function new();
            clear_quad();
        endfunction

        function void clear_quad();
            sextet_acc = '0;
            quad_pos   = '0;
            bad_seen   = 1'b0;
            pad_third  = 1'b0;
        endfunction

        // Returns 1 when the character belongs to the alphabet; '=' counts as zero.
        function bit lookup_sextet(input bit [7:0] c, output bit [5:0] sx);
            sx = 6'd0;
            if (c >= "A" && c <= "Z") begin
                sx = 6'(c - "A");
            end else if (c >= "a" && c <= "z") begin
                sx = 6'(c - "a" + 26);
            end else if (c >= "0" && c <= "9") begin
                sx = 6'(c - "0" + 52);
            end else if (c == "+") begin
                sx = 6'd62;
            end else if (c == "/") begin
                sx = 6'd63;
            end else if (c != PAD_CHAR) begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void push_result(bit [7:0] d, result_kind_t k, bit l);
            decoded_t r;
            r.data = d;
            r.kind = k;
            r.last = l;
            owed_results.push_back(r);
        endfunction

        function void note_char(bit [7:0] c, bit eot);
            bit [5:0]  sx;
            bit        in_alphabet;
            bit        is_pad;
            bit [23:0] group;
            int        n;
            in_alphabet = lookup_sextet(c, sx);
            is_pad = (c == PAD_CHAR);
            chars_in++;
            if (!in_alphabet) begin
                bad_seen = 1'b1;
            end
            if (quad_pos != 2'd3) begin
                sextet_acc = {sextet_acc[11:0], sx};
                if (quad_pos == 2'd2) begin
                    pad_third = is_pad;
                end
                quad_pos++;
                // A text that stops inside a quad owes one length error.
                if (eot) begin
                    push_result(8'd0, KIND_BAD_LENGTH, 1'b1);
                    clear_quad();
                end
                return;
            end
            if (bad_seen) begin
                push_result(8'd0, KIND_BAD_CHAR, 1'b1);
            end else begin
                group = {sextet_acc, sx};
                n = 3;
                // Padding only trims bytes on the quad that ends the text.
                if (eot) begin
                    if (pad_third) n--;
                    if (is_pad) n--;
                end
                for (int k = 0; k < n; k++) begin
                    push_result(group[23 - 8 * k -: 8], KIND_BYTE, k == n - 1);
                end
            end
            clear_quad();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [7:0] data, logic [1:0] kind, logic last);
            decoded_t want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: data=%02h kind=%0d last=%0b",
                                          data, kind, last));
                return;
            end
            want = owed_results.pop_front();
            if (kind !== want.kind) begin
                report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
            end
            if (data !== want.data) begin
                report_mismatch($sformatf("data %02h, wanted %02h", data, want.data));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("last %0b, wanted %0b", last, want.last));
            end
            case (want.kind)
                KIND_BYTE:     bytes_out++;
                KIND_BAD_CHAR: bad_char_quads++;
                default:       length_errors++;
            endcase
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    DecodeScoreboard decode_sb = new();
    bit [8:0] text_buf[$];   // {end_of_text, character}
    bit       tx_burst = 1'b0;
    bit       rx_burst = 1'b0;
    int       hold_off_cycles = 0;
    int       chars_sent = 0;
    int       input_stall_cycles = 0;
    bit       pressure_done = 1'b0;

    always #5 aclk = ~aclk;

    base64_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic bit [7:0] sextet_char(int unsigned v);
        if (v < 26) return 8'(8'h41 + v);
        if (v < 52) return 8'(8'h61 + v - 26);
        if (v < 62) return 8'(8'h30 + v - 52);
        if (v == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic bit [7:0] rand_b64_char();
        if ($urandom_range(0, 15) == 0) return PAD_CHAR;
        return sextet_char($urandom_range(0, 63));
    endfunction

    task send_char(bit [7:0] c, bit eot);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_sb.note_char(c, eot);
        chars_sent++;
    endtask

    task send_text(string str, bit eot_at_end);
        for (int i = 0; i < str.len(); i++) begin
            send_char(str[i], eot_at_end && (i == str.len() - 1));
        end
    endtask

    task send_buffer();
        bit [8:0] item;
        while (text_buf.size() > 0) begin
            item = text_buf.pop_front();
            send_char(item[7:0], item[8]);
        end
    endtask

    task queue_clean_quad(bit final_quad);
        bit [7:0] q[4];
        int       pads;
        for (int i = 0; i < 4; i++) q[i] = rand_b64_char();
        pads = 0;
        if (final_quad) begin
            pads = $urandom_range(0, 2);
            if (pads == 0 && q[3] == PAD_CHAR) q[3] = sextet_char($urandom_range(0, 63));
        end
        if (pads >= 1) q[3] = PAD_CHAR;
        if (pads == 2) q[2] = PAD_CHAR;
        for (int i = 0; i < 4; i++) text_buf.push_back({final_quad && i == 3, q[i]});
    endtask

    task build_random_unit();
        int kind;
        int n;
        int spot;
        bit [7:0] q[4];
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            // Text of one to four whole quads, the final one possibly padded.
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) queue_clean_quad(i == n - 1);
        end else if (kind < 15) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) queue_clean_quad(1'b0);
        end else if (kind < 17) begin
            for (int i = 0; i < 4; i++) q[i] = rand_b64_char();
            spot = $urandom_range(0, 3);
            q[spot] = 8'($urandom_range(0, 255));
            n = $urandom_range(0, 1);
            for (int i = 0; i < 4; i++) text_buf.push_back({n[0] && i == 3, q[i]});
        end else if (kind < 19) begin
            // Text cut short inside a quad.
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                q[0] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                   : rand_b64_char();
                text_buf.push_back({i == n - 1, q[0]});
            end
        end else begin
            for (int i = 0; i < 4; i++) text_buf.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
    endtask

    // Output side: random stalls, plus a long hold-off on request.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                hold_off_cycles--;
            end else if (!rx_burst && $urandom_range(0, 99) < 40) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            decode_sb.check_result(m_tdata, m_tuser, m_tlast);
        end
        if (aresetn && s_tvalid && !s_tready) begin
            input_stall_cycles++;
        end
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int random_start;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: plain quads, padding on final and non-final quads,
        // the alphabet edges, invalid characters and truncated text.
        send_text("+/09", 1'b0);
        send_text("TWE=", 1'b1);
        send_text("TQ==", 1'b1);
        send_text("TQ==", 1'b0);
        send_text("Az", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("9z", 1'b1);
        send_char(8'h80, 1'b0);
        send_text("x", 1'b1);
        send_text("Q", 1'b1);

        random_start = chars_sent;
        while (chars_sent - random_start < 145) begin
            tx_burst = ($urandom_range(0, 5) == 0);
            rx_burst = ($urandom_range(0, 5) == 0);
            if (!pressure_done && chars_sent - random_start >= 60) begin
                // Stall the output long enough that the quad queue fills up.
                pressure_done = 1'b1;
                tx_burst = 1'b1;
                hold_off_cycles = 80;
                for (int i = 0; i < 6; i++) queue_clean_quad(1'b0);
            end else begin
                build_random_unit();
            end
            send_buffer();
        end
        s_tvalid <= 1'b0;
        rx_burst = 1'b0;

        while (decode_sb.owed_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Run covered %0d characters: %0d bytes, %0d invalid-character quads, %0d length errors.",
                 decode_sb.chars_in, decode_sb.bytes_out, decode_sb.bad_char_quads,
                 decode_sb.length_errors);
        $display("Input side was held back for %0d cycles by output stalls.", input_stall_cycles);
        if (decode_sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
